### sv/i2cmra_pkg.sv
package i2cmra_pkg;

  // timer width and reset value of the segment length register
  localparam int unsigned PhaseTicksW     = 16;
  localparam logic [15:0] PhaseTicksReset = 16'd100;

  // completion status codes
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusAddrNak = 2'd1;
  localparam logic [1:0] StatusRegNak  = 2'd2;
  localparam logic [1:0] StatusDataNak = 2'd3;

  // which byte of the sequence is on the bus
  localparam logic [1:0] StageAddr = 2'd0;
  localparam logic [1:0] StageReg  = 2'd1;
  localparam logic [1:0] StageData = 2'd2;
  localparam logic [1:0] StageRead = 2'd3;

  // request kinds
  localparam logic KindWrite = 1'b0;
  localparam logic KindRead  = 1'b1;

  // read byte reported after a failed read
  localparam logic [7:0] ReadFail = 8'hFF;

endpackage

### sv/i2c_master_register_access_core.sv
// Each accepted tick word yields its result word in the following cycle.
// Throughput: one tick word per cycle unless the output stalls; the output
// register is refilled in the same cycle that its word is taken.
// Reset (rst_ni low, asynchronous): sequencer idle, lines released, status 0,
// read byte 0, segment length 100 ticks, no result word pending.
module i2c_master_register_access_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // tick words in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_req_i,
  input  logic        req_type_i,
  input  logic [6:0]  dev_addr_i,
  input  logic [7:0]  reg_addr_i,
  input  logic [7:0]  wr_data_i,
  input  logic        sda_in_i,
  // result words out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,
  output logic [7:0]  rd_data_o
);

  typedef enum logic [3:0] {
    PhIdle, PhStartA, PhStartB, PhTxLow, PhTxHigh, PhAckLow, PhAckHigh,
    PhRxLow, PhRxHigh, PhNackLow, PhNackHigh, PhNackTail, PhStopA, PhStopB,
    PhStopC
  } phase_e;

  localparam int unsigned TW = i2cmra_pkg::PhaseTicksW;

  // sequencer state
  phase_e          phase_q, phase_d;
  logic [3:0]      bit_cnt_q, bit_cnt_d;
  logic [7:0]      shift_q, shift_d;
  logic [TW-1:0]   tick_q, tick_d;
  logic [6:0]      dev_q, dev_d;
  logic [7:0]      reg_q, reg_d;
  logic [7:0]      data_q, data_d;
  logic            kind_q, kind_d;
  logic [1:0]      stage_q, stage_d;
  logic [1:0]      pend_q, pend_d;
  logic [1:0]      last_status_q, last_status_d;
  logic [7:0]      last_read_q, last_read_d;
  logic [TW-1:0]   phase_ticks_q;

  // output register
  logic            out_valid_q;
  logic            scl_q, sda_q, busy_q, done_q;
  logic [1:0]      status_q;
  logic [7:0]      rd_data_q;

  logic            in_acc;
  logic            scl_lvl, sda_lvl, done_d;
  logic [TW:0]     tick_inc;
  logic [3:0]      bit_inc;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign tick_inc   = {1'b0, tick_q} + {{TW{1'b0}}, 1'b1};

  // sequencer step for one tick
  always_comb begin
    phase_d       = phase_q;
    bit_cnt_d     = bit_cnt_q;
    shift_d       = shift_q;
    tick_d        = tick_q;
    dev_d         = dev_q;
    reg_d         = reg_q;
    data_d        = data_q;
    kind_d        = kind_q;
    stage_d       = stage_q;
    pend_d        = pend_q;
    last_status_d = last_status_q;
    last_read_d   = last_read_q;
    done_d        = 1'b0;
    scl_lvl       = 1'b1;
    sda_lvl       = 1'b1;
    bit_inc       = bit_cnt_q + 4'd1;

    // latch a new request when idle
    if (phase_q == PhIdle && start_req_i) begin
      kind_d  = req_type_i;
      dev_d   = dev_addr_i;
      reg_d   = reg_addr_i;
      data_d  = wr_data_i;
      stage_d = i2cmra_pkg::StageAddr;
      pend_d  = i2cmra_pkg::StatusOk;
      tick_d  = '0;
      phase_d = PhStartA;
    end

    // line levels of the current segment
    case (phase_d)
      PhStartA:   begin scl_lvl = 1'b1; sda_lvl = 1'b1;       end
      PhStartB:   begin scl_lvl = 1'b1; sda_lvl = 1'b0;       end
      PhTxLow:    begin scl_lvl = 1'b0; sda_lvl = shift_d[7]; end
      PhTxHigh:   begin scl_lvl = 1'b1; sda_lvl = shift_d[7]; end
      PhAckLow, PhRxLow, PhNackLow, PhNackTail: begin
        scl_lvl = 1'b0; sda_lvl = 1'b1;
      end
      PhStopA:    begin scl_lvl = 1'b0; sda_lvl = 1'b0;       end
      PhStopB:    begin scl_lvl = 1'b1; sda_lvl = 1'b0;       end
      default:    begin scl_lvl = 1'b1; sda_lvl = 1'b1;       end
    endcase

    // segment timer and advance
    if (phase_d != PhIdle) begin
      if (tick_inc >= {1'b0, phase_ticks_q}) begin
        tick_d = '0;
        case (phase_d)
          PhStartA: phase_d = PhStartB;
          PhStartB: begin
            shift_d   = {dev_d, (stage_d != i2cmra_pkg::StageAddr)};
            bit_cnt_d = '0;
            phase_d   = PhTxLow;
          end
          PhTxLow: phase_d = PhTxHigh;
          PhTxHigh: begin
            shift_d   = {shift_d[6:0], 1'b0};
            bit_cnt_d = bit_inc;
            phase_d   = (bit_inc >= 4'd8) ? PhAckLow : PhTxLow;
          end
          PhAckLow: phase_d = PhAckHigh;
          PhAckHigh: begin
            if (sda_in_i) begin
              // no acknowledge: record which byte failed, then stop
              if (stage_d == i2cmra_pkg::StageReg)
                pend_d = i2cmra_pkg::StatusRegNak;
              else if (stage_d == i2cmra_pkg::StageData && kind_d == i2cmra_pkg::KindWrite)
                pend_d = i2cmra_pkg::StatusDataNak;
              else
                pend_d = i2cmra_pkg::StatusAddrNak;
              phase_d = PhStopA;
            end else if (stage_d == i2cmra_pkg::StageAddr) begin
              stage_d   = i2cmra_pkg::StageReg;
              shift_d   = reg_d;
              bit_cnt_d = '0;
              phase_d   = PhTxLow;
            end else if (stage_d == i2cmra_pkg::StageReg) begin
              stage_d = i2cmra_pkg::StageData;
              if (kind_d == i2cmra_pkg::KindWrite) begin
                shift_d   = data_d;
                bit_cnt_d = '0;
                phase_d   = PhTxLow;
              end else begin
                phase_d = PhStartA;   // repeated start
              end
            end else if (kind_d == i2cmra_pkg::KindWrite) begin
              phase_d = PhStopA;
            end else begin
              stage_d   = i2cmra_pkg::StageRead;
              shift_d   = '0;
              bit_cnt_d = '0;
              phase_d   = PhRxLow;
            end
          end
          PhRxLow: phase_d = PhRxHigh;
          PhRxHigh: begin
            shift_d   = {shift_d[6:0], sda_in_i};
            bit_cnt_d = bit_inc;
            phase_d   = (bit_inc >= 4'd8) ? PhNackLow : PhRxLow;
          end
          PhNackLow:  phase_d = PhNackHigh;
          PhNackHigh: phase_d = PhNackTail;
          PhNackTail: phase_d = PhStopA;
          PhStopA:    phase_d = PhStopB;
          PhStopB:    phase_d = PhStopC;
          PhStopC: begin
            last_status_d = pend_d;
            if (kind_d == i2cmra_pkg::KindWrite)
              last_read_d = '0;
            else
              last_read_d = (pend_d != i2cmra_pkg::StatusOk) ? i2cmra_pkg::ReadFail
                                                              : shift_d;
            phase_d = PhIdle;
            done_d  = 1'b1;
          end
          default: phase_d = PhIdle;
        endcase
      end else begin
        tick_d = tick_inc[TW-1:0];
      end
    end
  end

  // state, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhIdle;
      bit_cnt_q     <= '0;
      shift_q       <= '0;
      tick_q        <= '0;
      dev_q         <= '0;
      reg_q         <= '0;
      data_q        <= '0;
      kind_q        <= i2cmra_pkg::KindWrite;
      stage_q       <= i2cmra_pkg::StageAddr;
      pend_q        <= i2cmra_pkg::StatusOk;
      last_status_q <= i2cmra_pkg::StatusOk;
      last_read_q   <= '0;
      phase_ticks_q <= i2cmra_pkg::PhaseTicksReset;
      out_valid_q   <= 1'b0;
      scl_q         <= 1'b1;
      sda_q         <= 1'b1;
      busy_q        <= 1'b0;
      done_q        <= 1'b0;
      status_q      <= '0;
      rd_data_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        phase_ticks_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        phase_q       <= phase_d;
        bit_cnt_q     <= bit_cnt_d;
        shift_q       <= shift_d;
        tick_q        <= tick_d;
        dev_q         <= dev_d;
        reg_q         <= reg_d;
        data_q        <= data_d;
        kind_q        <= kind_d;
        stage_q       <= stage_d;
        pend_q        <= pend_d;
        last_status_q <= last_status_d;
        last_read_q   <= last_read_d;
        out_valid_q   <= 1'b1;
        scl_q         <= scl_lvl;
        sda_q         <= sda_lvl;
        busy_q        <= (phase_d != PhIdle);
        done_q        <= done_d;
        status_q      <= last_status_d;
        rd_data_q     <= last_read_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_out_o   = scl_q;
  assign sda_out_o   = sda_q;
  assign busy_res_o  = busy_q;
  assign done_res_o  = done_q;
  assign status_o    = status_q;
  assign rd_data_o   = rd_data_q;

endmodule
